FILE: rtl/core/tgasd_pkg.sv
// ----------------------------------------------------------------------------
// tgasd_pkg
// Shared types and constants of the TGA texel stream decoder: register map,
// pixel format codes, configuration and pixel structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgasd_pkg;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      REG_PIXEL_FORMAT  = 3'd0,
      REG_RLE_ENABLE    = 3'd1,
      REG_KEY_ENABLE    = 3'd2,
      REG_KEY_COLOR     = 3'd3,
      REG_FILL_ALPHA    = 3'd4,
      REG_BLEND_WEIGHT  = 3'd5,
      REG_DIFFUSE_COLOR = 3'd6,
      REG_IMAGE_PIXELS  = 3'd7
   } reg_idx_type;

   localparam logic [1:0] FMT_RGB565     = 2'd0;
   localparam logic [1:0] FMT_BGR24      = 2'd1;
   localparam logic [1:0] FMT_BGRA32     = 2'd2;
   localparam logic [1:0] FMT_BGRA32_ALT = 2'd3;

   localparam logic [1:0]  RST_PIXEL_FORMAT = FMT_BGR24;
   localparam logic [7:0]  RST_FILL_ALPHA   = 8'd255;
   localparam logic [8:0]  RST_BLEND_WEIGHT = 9'd256;
   localparam logic [31:0] RST_IMAGE_PIXELS = 32'd1;

   localparam logic [7:0] RUN_HDR_BIAS = 8'd127;

   typedef struct packed {
      logic [1:0]  pixel_format;
      logic        rle_enable;
      logic        key_enable;
      logic [23:0] key_color;
      logic [7:0]  fill_alpha;
      logic [8:0]  blend_weight;
      logic [23:0] diffuse_color;
      logic [31:0] image_pixels;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] repeat_count;
      logic       last_pixel;
   } pix_type;

endpackage

FILE: rtl/core/tgasd_csr.sv
// ----------------------------------------------------------------------------
// tgasd_csr
// APB-style register file holding the decoder configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgasd_csr
   import tgasd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format  <= RST_PIXEL_FORMAT;
         cfg_ff.rle_enable    <= 1'b0;
         cfg_ff.key_enable    <= 1'b0;
         cfg_ff.key_color     <= '0;
         cfg_ff.fill_alpha    <= RST_FILL_ALPHA;
         cfg_ff.blend_weight  <= RST_BLEND_WEIGHT;
         cfg_ff.diffuse_color <= '0;
         cfg_ff.image_pixels  <= RST_IMAGE_PIXELS;
      end else if (wr_en) begin
         case (idx)
            REG_PIXEL_FORMAT:  cfg_ff.pixel_format  <= pwdata[1:0];
            REG_RLE_ENABLE:    cfg_ff.rle_enable    <= pwdata[0];
            REG_KEY_ENABLE:    cfg_ff.key_enable    <= pwdata[0];
            REG_KEY_COLOR:     cfg_ff.key_color     <= pwdata[23:0];
            REG_FILL_ALPHA:    cfg_ff.fill_alpha    <= pwdata[7:0];
            REG_BLEND_WEIGHT:  cfg_ff.blend_weight  <= pwdata[8:0];
            REG_DIFFUSE_COLOR: cfg_ff.diffuse_color <= pwdata[23:0];
            REG_IMAGE_PIXELS:  cfg_ff.image_pixels  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_PIXEL_FORMAT:  prdata = {30'd0, cfg_ff.pixel_format};
         REG_RLE_ENABLE:    prdata = {31'd0, cfg_ff.rle_enable};
         REG_KEY_ENABLE:    prdata = {31'd0, cfg_ff.key_enable};
         REG_KEY_COLOR:     prdata = {8'd0, cfg_ff.key_color};
         REG_FILL_ALPHA:    prdata = {24'd0, cfg_ff.fill_alpha};
         REG_BLEND_WEIGHT:  prdata = {23'd0, cfg_ff.blend_weight};
         REG_DIFFUSE_COLOR: prdata = {8'd0, cfg_ff.diffuse_color};
         REG_IMAGE_PIXELS:  prdata = cfg_ff.image_pixels;
         default:           prdata = '0;
      endcase
   end

endmodule

FILE: rtl/core/tgasd_decode.sv
// ----------------------------------------------------------------------------
// tgasd_decode
// Byte assembly, RLE packet tracking and pixel expansion; holds the stream
// state and clips repeat counts at the image end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgasd_decode
   import tgasd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] data_byte,
   input  cfg_type    cfg,
   output pix_type    pix
);

   logic [1:0]  phase_ff, phase_in;
   logic [23:0] color_ff, color_in;
   logic        expect_ff, expect_in;
   logic        is_run_ff, is_run_in;
   logic [7:0]  lit_left_ff, lit_left_in;
   logic [7:0]  run_len_ff, run_len_in;
   logic [31:0] done_ff, done_in;

   logic [1:0]  last_idx;
   logic        packed_mode;
   logic        hdr;
   logic        complete;
   logic [23:0] color_new;
   logic [7:0]  r, g, b;
   logic        key_hit;
   logic [7:0]  rep_raw;
   logic [31:0] img_cnt;
   logic [31:0] rem;
   logic        is_last;
   logic [7:0]  rep_out;
   logic [7:0]  lit_dec;

   always_comb begin
      case (cfg.pixel_format)
         FMT_RGB565: last_idx = 2'd1;
         FMT_BGR24:  last_idx = 2'd2;
         default:    last_idx = 2'd3;
      endcase
   end

   assign packed_mode = cfg.rle_enable & (cfg.pixel_format != FMT_RGB565);
   assign hdr         = packed_mode & expect_ff;
   assign complete    = !hdr && !(phase_ff < last_idx);

   always_comb begin
      color_new = color_ff;
      case (phase_ff)
         2'd0:    color_new[7:0]   = data_byte;
         2'd1:    color_new[15:8]  = data_byte;
         2'd2:    color_new[23:16] = data_byte;
         default: ;
      endcase
   end

   always_comb begin
      if (cfg.pixel_format == FMT_RGB565) begin
         b = {color_new[4:0], 3'b000};
         g = {color_new[10:5], 2'b00};
         r = {color_new[15:11], 3'b000};
      end else begin
         b = color_new[7:0];
         g = color_new[15:8];
         r = color_new[23:16];
      end
   end

   assign key_hit = !packed_mode && cfg.key_enable && ({b, g, r} == cfg.key_color);

   always_comb begin
      if (packed_mode && is_run_ff) begin
         rep_raw = (run_len_ff != 8'd0) ? run_len_ff : 8'd1;
      end else begin
         rep_raw = 8'd1;
      end
   end

   assign img_cnt = (cfg.image_pixels != 32'd0) ? cfg.image_pixels : 32'd1;
   assign rem     = (img_cnt > done_ff) ? (img_cnt - done_ff) : 32'd1;
   assign is_last = {24'd0, rep_raw} >= rem;
   assign rep_out = is_last ? rem[7:0] : rep_raw;
   assign lit_dec = (lit_left_ff != 8'd0) ? (lit_left_ff - 8'd1) : 8'd0;

   assign pix.valid        = complete;
   assign pix.red          = r;
   assign pix.green        = g;
   assign pix.blue         = b;
   assign pix.alpha        = key_hit ? 8'd0 : cfg.fill_alpha;
   assign pix.repeat_count = rep_out;
   assign pix.last_pixel   = is_last;

   always_comb begin
      phase_in    = phase_ff;
      color_in    = color_ff;
      expect_in   = expect_ff;
      is_run_in   = is_run_ff;
      lit_left_in = lit_left_ff;
      run_len_in  = run_len_ff;
      done_in     = done_ff;
      if (fire) begin
         if (!packed_mode) begin
            expect_in = 1'b0;
         end
         if (hdr) begin
            if (data_byte[7]) begin
               is_run_in  = 1'b1;
               run_len_in = data_byte - RUN_HDR_BIAS;
            end else begin
               is_run_in   = 1'b0;
               lit_left_in = data_byte + 8'd1;
            end
            expect_in = 1'b0;
            phase_in  = 2'd0;
            color_in  = '0;
         end else if (!complete) begin
            color_in = color_new;
            phase_in = phase_ff + 2'd1;
         end else begin
            phase_in = 2'd0;
            color_in = '0;
            if (packed_mode) begin
               if (is_run_ff) begin
                  expect_in = 1'b1;
               end else begin
                  lit_left_in = lit_dec;
                  if (lit_dec == 8'd0) begin
                     expect_in = 1'b1;
                  end
               end
            end
            if (is_last) begin
               expect_in   = 1'b1;
               is_run_in   = 1'b0;
               lit_left_in = '0;
               run_len_in  = '0;
               done_in     = '0;
            end else begin
               done_in = done_ff + {24'd0, rep_out};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         color_ff    <= '0;
         expect_ff   <= 1'b1;
         is_run_ff   <= 1'b0;
         lit_left_ff <= '0;
         run_len_ff  <= '0;
         done_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         color_ff    <= color_in;
         expect_ff   <= expect_in;
         is_run_ff   <= is_run_in;
         lit_left_ff <= lit_left_in;
         run_len_ff  <= run_len_in;
         done_ff     <= done_in;
      end
   end

endmodule

FILE: rtl/core/tgasd_blend.sv
// ----------------------------------------------------------------------------
// tgasd_blend
// Per-channel mix of the decoded color with the diffuse color, Q1.8 weight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgasd_blend
   import tgasd_pkg::*;
(
   input  pix_type     pix_raw,
   input  logic [8:0]  blend_weight,
   input  logic [23:0] diffuse_color,
   output pix_type     pix_mix
);

   logic        bypass;
   logic [7:0]  w;
   logic [8:0]  wc;
   logic [16:0] sum_r, sum_g, sum_b;

   assign bypass = blend_weight[8];
   assign w      = blend_weight[7:0];
   assign wc     = 9'd256 - {1'b0, w};

   assign sum_r = ({9'd0, pix_raw.red} * {9'd0, w})
                + ({9'd0, diffuse_color[7:0]} * {8'd0, wc});
   assign sum_g = ({9'd0, pix_raw.green} * {9'd0, w})
                + ({9'd0, diffuse_color[15:8]} * {8'd0, wc});
   assign sum_b = ({9'd0, pix_raw.blue} * {9'd0, w})
                + ({9'd0, diffuse_color[23:16]} * {8'd0, wc});

   always_comb begin
      pix_mix = pix_raw;
      if (!bypass) begin
         pix_mix.red   = sum_r[15:8];
         pix_mix.green = sum_g[15:8];
         pix_mix.blue  = sum_b[15:8];
      end
   end

endmodule

FILE: rtl/core/tga_texel_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// tga_texel_stream_decoder_unit
// Path: a pixel's final byte passes the input register, then the result
// register; an output stall holds the byte or the pixel where it stands.
// Throughput: one byte per cycle unless stalled; one decode-and-blend pass.
// Reset: synchronous; registers return to defaults, stream waits for a
// packet header or first pixel byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tga_texel_stream_decoder_unit
   import tgasd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_red,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_blue,
   output logic [7:0]        rsp_alpha,
   output logic [7:0]        rsp_repeat_count,
   output logic              rsp_last_pixel,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type    cfg;
   pix_type    pix_raw;
   pix_type    pix_mix;
   pix_type    out_ff;
   logic       out_valid_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       fire;

   tgasd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tgasd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (in_byte_ff),
      .cfg       (cfg),
      .pix       (pix_raw)
   );

   tgasd_blend u_blend (
      .pix_raw       (pix_raw),
      .blend_weight  (cfg.blend_weight),
      .diffuse_color (cfg.diffuse_color),
      .pix_mix       (pix_mix)
   );

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= fire && pix_raw.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
      end
      if (fire && pix_raw.valid) begin
         out_ff <= pix_mix;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_red          = out_ff.red;
   assign rsp_green        = out_ff.green;
   assign rsp_blue         = out_ff.blue;
   assign rsp_alpha        = out_ff.alpha;
   assign rsp_repeat_count = out_ff.repeat_count;
   assign rsp_last_pixel   = out_ff.last_pixel;

`ifndef SYNTHESIS
   a_hold_pending: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("pending request lost");

   a_rep_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_repeat_count != 8'd0 && rsp_repeat_count <= 8'd128))
      else $error("repeat count out of range");

   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      (fire && pix_raw.valid && pix_raw.last_pixel) |=> (rsp_valid && rsp_last_pixel))
      else $error("image end not delivered");
`endif

endmodule

FILE: verif/tb_tga_texel_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_tga_texel_stream_decoder_unit
// Self-checking bench for the TGA texel stream decoder. Pixel-data bytes are
// queued per phase and driven with random gaps. Each accepted request runs
// through a local decoder model that queues the expected RGBA pixel and
// repeat count. The response monitor stalls at random, twice for a long
// stretch, and checks every pixel field against the oldest expected entry.
// Registers are rewritten over APB between phases while the block is idle:
// raw 16/24/32-bit data, RLE packets, color key, blending and image ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tga_texel_stream_decoder_unit;
   import tgasd_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 400;
   localparam int RAND_PHASES  = 12;
   localparam int PHASE_ITEMS  = 128;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] repeat_count;
      logic       last_pixel;
   } texel_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [7:0]        req_data_byte = 8'd0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [7:0]        rsp_red;
   logic [7:0]        rsp_green;
   logic [7:0]        rsp_blue;
   logic [7:0]        rsp_alpha;
   logic [7:0]        rsp_repeat_count;
   logic              rsp_last_pixel;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   tga_texel_stream_decoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_last_pixel   (rsp_last_pixel),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // stimulus and expected pixels
   logic [7:0] pending_bytes[$];
   texel_type  texel_q[$];
   int         queued_total = 0;
   int         bytes_taken = 0;
   int         errors = 0;
   int         cycle_count = 0;
   logic       idle_mode = 1'b0;
   logic       hold_token = 1'b0;

   // decoder model state and register copy
   cfg_type     cfg;
   logic [1:0]  px_phase;
   logic [23:0] px_bytes;
   logic        want_header;
   logic        in_run;
   logic [7:0]  lit_left;
   logic [7:0]  run_len;
   logic [31:0] pixels_done;

   function automatic void restart_image();
      px_phase    = 2'd0;
      px_bytes    = 24'd0;
      want_header = 1'b1;
      in_run      = 1'b0;
      lit_left    = 8'd0;
      run_len     = 8'd0;
      pixels_done = 32'd0;
   endfunction

   function automatic int bytes_per_pixel();
      if (cfg.pixel_format == FMT_RGB565) return 2;
      if (cfg.pixel_format == FMT_BGR24) return 3;
      return 4;
   endfunction

   function automatic logic rle_active();
      return cfg.rle_enable && (cfg.pixel_format != FMT_RGB565);
   endfunction

   function automatic longint pixels_remaining();
      longint img;
      img = (cfg.image_pixels == 32'd0) ? 64'd1 : longint'(cfg.image_pixels);
      return (img > longint'(pixels_done)) ? img - longint'(pixels_done) : 64'd1;
   endfunction

   function automatic logic [7:0] blend(logic [7:0] c, logic [7:0] d);
      int unsigned w;
      int unsigned s;
      w = cfg.blend_weight;
      if (w >= 256) return c;
      s = int'(c) * w + int'(d) * (256 - w);
      return s[15:8];
   endfunction

   function automatic void push_texel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic [7:0] a, logic [7:0] rep);
      longint    rem;
      texel_type t;
      rem = pixels_remaining();
      t.last_pixel = (longint'(rep) >= rem);
      t.repeat_count = t.last_pixel ? rem[7:0] : rep;
      t.red   = blend(r, cfg.diffuse_color[7:0]);
      t.green = blend(g, cfg.diffuse_color[15:8]);
      t.blue  = blend(b, cfg.diffuse_color[23:16]);
      t.alpha = a;
      texel_q.push_back(t);
      if (t.last_pixel) restart_image();
      else pixels_done = pixels_done + t.repeat_count;
   endfunction

   function automatic void decode_byte(logic [7:0] din);
      int         nb;
      logic       rle_on;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
      nb = bytes_per_pixel();
      rle_on = rle_active();
      if (!rle_on) want_header = 1'b0;
      if (rle_on && want_header) begin
         if (din < 8'd128) begin
            in_run = 1'b0;
            lit_left = din + 8'd1;
         end else begin
            in_run = 1'b1;
            run_len = din - RUN_HDR_BIAS;
         end
         want_header = 1'b0;
         px_phase = 2'd0;
         px_bytes = 24'd0;
         return;
      end
      if (px_phase < 2'd3) px_bytes[8*px_phase +: 8] = din;
      if (int'(px_phase) + 1 < nb) begin
         px_phase = px_phase + 2'd1;
         return;
      end
      px_phase = 2'd0;
      if (cfg.pixel_format == FMT_RGB565) begin
         b = {px_bytes[4:0], 3'b000};
         g = {px_bytes[10:5], 2'b00};
         r = {px_bytes[15:11], 3'b000};
      end else begin
         b = px_bytes[7:0];
         g = px_bytes[15:8];
         r = px_bytes[23:16];
      end
      px_bytes = 24'd0;
      a = cfg.fill_alpha;
      if (!rle_on) begin
         if (cfg.key_enable && ({b, g, r} == cfg.key_color)) a = 8'd0;
         push_texel(r, g, b, a, 8'd1);
      end else if (in_run) begin
         want_header = 1'b1;
         push_texel(r, g, b, a, (run_len != 8'd0) ? run_len : 8'd1);
      end else begin
         if (lit_left > 8'd0) lit_left = lit_left - 8'd1;
         if (lit_left == 8'd0) want_header = 1'b1;
         push_texel(r, g, b, a, 8'd1);
      end
   endfunction

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // request driver
   int gap_left = 0;

   always @(posedge clock) begin
      logic       nv;
      logic [7:0] nd;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         nv = req_valid;
         nd = req_data_byte;
         if (req_valid && !req_stall) begin
            decode_byte(req_data_byte);
            bytes_taken++;
            nv = 1'b0;
            gap_left = idle_mode ? gap_length() : 0;
         end
         if (!nv) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_bytes.size() > 0) begin
               nv = 1'b1;
               nd = pending_bytes.pop_front();
            end
         end
         req_valid <= nv;
         req_data_byte <= nd;
      end
   end

   // response monitor
   int   stall_left = 0;
   int   hold_left = 0;
   logic hold_seen = 1'b0;

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      logic      ns;
      texel_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (texel_q.size() == 0) begin
               $display("%0t: unexpected pixel, expected none, actual %h %h %h %h rep %0d last %b",
                        $time, rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_repeat_count,
                        rsp_last_pixel);
               errors++;
            end else begin
               e = texel_q.pop_front();
               check_field("red", e.red, rsp_red);
               check_field("green", e.green, rsp_green);
               check_field("blue", e.blue, rsp_blue);
               check_field("alpha", e.alpha, rsp_alpha);
               check_field("repeat_count", e.repeat_count, rsp_repeat_count);
               check_field("last_pixel", {7'd0, e.last_pixel}, {7'd0, rsp_last_pixel});
            end
         end
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            ns = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            ns = 1'b1;
         end else if (idle_mode && $urandom_range(0, 3) == 0) begin
            stall_left = gap_length();
            ns = (stall_left > 0);
            if (ns) stall_left--;
         end else begin
            ns = 1'b0;
         end
         rsp_stall <= ns;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d pixels outstanding", $time, texel_q.size());
         $display("FAILURE");
         $finish;
      end
   end

   // stimulus helpers, called right after a rising edge
   task automatic csr_write(reg_idx_type idx, logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_PIXEL_FORMAT:  cfg.pixel_format  = val[1:0];
         REG_RLE_ENABLE:    cfg.rle_enable    = val[0];
         REG_KEY_ENABLE:    cfg.key_enable    = val[0];
         REG_KEY_COLOR:     cfg.key_color     = val[23:0];
         REG_FILL_ALPHA:    cfg.fill_alpha    = val[7:0];
         REG_BLEND_WEIGHT:  cfg.blend_weight  = val[8:0];
         REG_DIFFUSE_COLOR: cfg.diffuse_color = val[23:0];
         REG_IMAGE_PIXELS:  cfg.image_pixels  = val;
         default: ;
      endcase
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_cfg(logic [1:0] fmt, logic rle, logic key_en, logic [23:0] key,
                          logic [7:0] fill, logic [8:0] w, logic [23:0] diffuse,
                          logic [31:0] img);
      csr_write(REG_PIXEL_FORMAT, {30'd0, fmt});
      csr_write(REG_RLE_ENABLE, {31'd0, rle});
      csr_write(REG_KEY_ENABLE, {31'd0, key_en});
      csr_write(REG_KEY_COLOR, {8'd0, key});
      csr_write(REG_FILL_ALPHA, {24'd0, fill});
      csr_write(REG_BLEND_WEIGHT, {23'd0, w});
      csr_write(REG_DIFFUSE_COLOR, {8'd0, diffuse});
      csr_write(REG_IMAGE_PIXELS, img);
   endtask

   // queue n bytes of w, low byte first
   task automatic push_word(logic [31:0] w, int n);
      for (int i = 0; i < n; i++) begin
         pending_bytes.push_back(w[8*i +: 8]);
         queued_total++;
      end
   endtask

   task automatic push_random(int n);
      for (int i = 0; i < n; i++) push_word($urandom, 1);
   endtask

   task automatic push_pixel(int nb, logic key_on, logic [23:0] key, logic [15:0] key16);
      if (key_on && $urandom_range(0, 5) == 0) begin
         if (nb == 2) push_word({16'd0, key16}, 2);
         else push_word({8'($urandom), key[7:0], key[15:8], key[23:16]}, nb);
      end else begin
         push_word($urandom, nb);
      end
   endtask

   task automatic wait_idle();
      while (bytes_taken != queued_total || texel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(int n_items);
      logic [1:0]  fmt;
      logic        key_on;
      logic [23:0] key;
      logic [15:0] key16;
      logic [8:0]  w;
      logic [7:0]  fill;
      logic [31:0] img;
      longint      img_eff;
      longint      img_left;
      longint      rem;
      longint      pix;
      int          nb;
      int          fill_n;
      int          start;
      int          npix;
      int          rl;
      fmt = 2'($urandom_range(0, 3));
      key_on = 1'($urandom_range(0, 1));
      key16 = 16'($urandom);
      if (fmt == FMT_RGB565) key = {key16[4:0], 3'b000, key16[10:5], 2'b00, key16[15:11], 3'b000};
      else key = 24'($urandom);
      case ($urandom_range(0, 6))
         0: w = 9'd0;
         1: w = 9'd1;
         2: w = 9'd255;
         3: w = 9'h1ff;
         4: w = 9'($urandom);
         default: w = 9'd256;
      endcase
      case ($urandom_range(0, 3))
         0: fill = 8'd0;
         1: fill = 8'd255;
         default: fill = 8'($urandom);
      endcase
      case ($urandom_range(0, 11))
         0: img = 32'd0;
         1: img = 32'hffff_ffff;
         2: img = $urandom;
         3: img = 32'd1;
         4, 5: img = $urandom_range(65, 5000);
         default: img = $urandom_range(2, 64);
      endcase
      set_cfg(fmt, ($urandom_range(0, 3) != 0), key_on, key, fill, w, 24'($urandom), img);

      // finish whatever pixel or packet the last phase left open
      nb = bytes_per_pixel();
      img_eff = (cfg.image_pixels == 32'd0) ? 64'd1 : longint'(cfg.image_pixels);
      rem = pixels_remaining();
      img_left = rem;
      fill_n = (int'(px_phase) + 1 >= nb) ? 1 : nb - int'(px_phase);
      if (rle_active() && !want_header) begin
         if (in_run) begin
            push_random(fill_n);
            pix = (run_len != 8'd0) ? longint'(run_len) : 64'd1;
         end else begin
            pix = (lit_left > 8'd1) ? longint'(lit_left) : 64'd1;
            if (pix > rem) pix = rem;
            push_random(fill_n + int'(pix - 1) * nb);
         end
         img_left = (pix >= rem) ? img_eff : rem - pix;
      end else if (!rle_active() && px_phase != 2'd0) begin
         push_random(fill_n);
      end

      start = queued_total;
      while (queued_total - start < n_items * 9 / 10) begin
         if (!rle_active()) begin
            push_pixel(nb, key_on, key, key16);
         end else if ($urandom_range(0, 1) == 0) begin
            npix = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
            if (longint'(npix) > img_left) npix = int'(img_left);
            push_word(npix - 1, 1);
            for (int i = 0; i < npix; i++) push_pixel(nb, key_on, key, key16);
            img_left = img_left - npix;
            if (img_left == 0) img_left = img_eff;
         end else begin
            rl = $urandom_range(1, 128);
            push_word(rl + 127, 1);
            push_pixel(nb, key_on, key, key16);
            img_left = (longint'(rl) >= img_left) ? img_eff : img_left - rl;
         end
      end
      // broken packets and stray bytes
      while (queued_total - start < n_items) push_random($urandom_range(1, 5));
   endtask

   initial begin
      cfg.pixel_format  = RST_PIXEL_FORMAT;
      cfg.rle_enable    = 1'b0;
      cfg.key_enable    = 1'b0;
      cfg.key_color     = 24'd0;
      cfg.fill_alpha    = RST_FILL_ALPHA;
      cfg.blend_weight  = RST_BLEND_WEIGHT;
      cfg.diffuse_color = 24'd0;
      cfg.image_pixels  = RST_IMAGE_PIXELS;
      restart_image();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: one-pixel 24-bit image
      push_word(32'h0012_3456, 3);
      wait_idle();

      // 565 with color key; RLE bit is ignored for 16-bit
      set_cfg(FMT_RGB565, 1'b1, 1'b1, 24'hf8fcf8, 8'h5a, 9'd256, 24'd0, 32'd3);
      push_word(32'h0000, 2);
      push_word(32'hffff, 2);
      push_word(32'hf81f, 2);
      wait_idle();

      // 32-bit, zero weight, zero image size
      set_cfg(FMT_BGRA32, 1'b0, 1'b0, 24'd0, 8'd255, 9'd0, 24'hffffff, 32'd0);
      push_word(32'haa12_3456, 4);
      wait_idle();

      // format three, weight above one
      set_cfg(FMT_BGRA32_ALT, 1'b0, 1'b1, 24'h563412, 8'd0, 9'h1ff, 24'd0, 32'd2);
      push_word(32'h0012_3456, 4);
      wait_idle();

      // RLE: full run, single literal, run clipped at image end
      set_cfg(FMT_BGR24, 1'b1, 1'b1, 24'd0, 8'd200, 9'd128, 24'h302010, 32'd200);
      push_word(32'hff, 1);
      push_word(32'h00ff_80ff, 3);
      push_word(32'h00, 1);
      push_word(32'h0000_0000, 3);
      push_word(32'hff, 1);
      push_word(32'h0001_0203, 3);
      wait_idle();

      // image size lowered below pixels already done
      set_cfg(FMT_BGR24, 1'b0, 1'b0, 24'd0, 8'd255, 9'd256, 24'd0, 32'd10);
      push_word(32'h0011_2233, 3);
      push_word(32'h0044_5566, 3);
      wait_idle();
      csr_write(REG_IMAGE_PIXELS, 32'd1);
      push_word(32'h0077_8899, 3);
      wait_idle();

      for (int k = 0; k < RAND_PHASES; k++) begin
         idle_mode <= (k % 4 != 1);
         if (k == 2 || k == 9) hold_token <= ~hold_token;
         random_phase(PHASE_ITEMS);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
